@@ src/bsc_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and helpers for the barometric sensor compensation block
// no dependencies

package bsc_pkg;

  // field and datapath widths
  localparam int RAW_W     = 24;
  localparam int COEF_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int DT_W      = 25;
  localparam int MUL_A_W   = 25;
  localparam int MUL_B_W   = 18;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int SENS_W    = 34;
  localparam int SENS_LO_W = 17;
  localparam int OFF_W     = 36;
  localparam int ACC_W     = 58;
  localparam int DIFF_W    = 38;
  localparam int VALUE_W   = 22;

  // scalings of the compensation formulas
  localparam int TEMP_BASE      = 2000;
  localparam int TEMP_SHIFT     = 23;
  localparam int REF_TEMP_SHIFT = 8;
  localparam int OFF_REF_SHIFT  = 17;
  localparam int OFF_SHIFT      = 7;
  localparam int SENS_REF_SHIFT = 15;
  localparam int SENS_SHIFT     = 9;
  localparam int PROD_SHIFT     = 21;
  localparam int OUT_SHIFT      = 15;

  // saturation limits of the result
  localparam logic signed [DIFF_W-1:0] VALUE_MAX = DIFF_W'((64'sd1 <<< (VALUE_W - 1)) - 64'sd1);
  localparam logic signed [DIFF_W-1:0] VALUE_MIN = DIFF_W'(-(64'sd1 <<< (VALUE_W - 1)));

  // item kinds
  localparam logic OP_TEMP = 1'b0;
  localparam logic OP_PRES = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SENS_AT_REF      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_AT_REF    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMP_COEF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP_COEF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REF_TEMPERATURE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_SLOPE       = 3'd5;

  typedef struct packed {
    logic [COEF_W-1:0] sens_at_ref;
    logic [COEF_W-1:0] offset_at_ref;
    logic [COEF_W-1:0] sens_temp_coef;
    logic [COEF_W-1:0] offset_temp_coef;
    logic [COEF_W-1:0] ref_temperature;
    logic [COEF_W-1:0] temp_slope;
  } coef_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_T,
    ST_FIN_T,
    ST_MUL_OFF,
    ST_MUL_SENS,
    ST_SENS,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ACC_HI,
    ST_SUB,
    ST_FIN_P
  } state_t;

  // clamp a wide signed result to the output range
  function automatic logic signed [VALUE_W-1:0] saturate(input logic signed [DIFF_W-1:0] v);
    logic signed [VALUE_W-1:0] r;
    if (v > VALUE_MAX) begin
      r = VALUE_MAX[VALUE_W-1:0];
    end else if (v < VALUE_MIN) begin
      r = VALUE_MIN[VALUE_W-1:0];
    end else begin
      r = v[VALUE_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ src/bsc_regs.sv @@
`timescale 1ns / 1ps
// calibration coefficient registers, written over the configuration channel
// depends on bsc_pkg

module bsc_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bsc_pkg::COEF_W-1:0]      cfg_data,
  output bsc_pkg::coef_t                  coef
);
  import bsc_pkg::*;

  // one register per index, others ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SENS_AT_REF:      coef.sens_at_ref      <= cfg_data;
        REG_OFFSET_AT_REF:    coef.offset_at_ref    <= cfg_data;
        REG_SENS_TEMP_COEF:   coef.sens_temp_coef   <= cfg_data;
        REG_OFFSET_TEMP_COEF: coef.offset_temp_coef <= cfg_data;
        REG_REF_TEMPERATURE:  coef.ref_temperature  <= cfg_data;
        REG_TEMP_SLOPE:       coef.temp_slope       <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ src/bsc_mul.sv @@
`timescale 1ns / 1ps
// shared signed multiplier with a registered product
// depends on bsc_pkg

module bsc_mul (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [bsc_pkg::MUL_A_W-1:0]    a,
  input  logic signed [bsc_pkg::MUL_B_W-1:0]    b,
  output logic signed [bsc_pkg::MUL_P_W-1:0]    p
);
  import bsc_pkg::*;

  // product holds until the next issue
  always_ff @(posedge clk) begin
    if (en) begin
      p <= MUL_P_W'(a) * MUL_P_W'(b);
    end
  end

endmodule

@@ src/bsc_core.sv @@
`timescale 1ns / 1ps
// sequencer and accumulators that run the compensation through the shared multiplier
// depends on bsc_pkg and a bsc_mul instance in the top level

module bsc_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  bsc_pkg::coef_t                        coef,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  op,
  input  logic [bsc_pkg::RAW_W-1:0]             raw_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  kind,
  output logic signed [bsc_pkg::VALUE_W-1:0]    value,
  output logic                                  mul_en,
  output logic signed [bsc_pkg::MUL_A_W-1:0]    mul_a,
  output logic signed [bsc_pkg::MUL_B_W-1:0]    mul_b,
  input  logic signed [bsc_pkg::MUL_P_W-1:0]    mul_p
);
  import bsc_pkg::*;

  state_t                     state;
  state_t                     state_next;
  logic signed [DT_W-1:0]     temp_diff;
  logic [RAW_W-1:0]           raw_q;
  logic                       op_q;
  logic signed [OFF_W-1:0]    off;
  logic signed [SENS_W-1:0]   sens;
  logic signed [ACC_W-1:0]    acc;
  logic signed [DIFF_W-1:0]   diff;
  logic                       in_beat;
  logic                       out_write;
  logic signed [VALUE_W-1:0]  value_next;
  logic signed [DIFF_W-1:0]   temp_res;
  logic [DT_W-1:0]            dt_new;

  assign in_stall = (state != ST_IDLE);
  assign in_beat  = in_valid && !in_stall;

  // temperature difference of a new conversion
  assign dt_new = DT_W'({1'b0, raw_value})
                - DT_W'({coef.ref_temperature, {REF_TEMP_SHIFT{1'b0}}});

  // temperature result before clamping
  assign temp_res = DIFF_W'(mul_p >>> TEMP_SHIFT) + DIFF_W'(TEMP_BASE);

  // next state, multiplier operands and output write
  always_comb begin
    state_next = state;
    mul_en     = 1'b0;
    mul_a      = temp_diff;
    mul_b      = $signed({2'b00, coef.temp_slope});
    out_write  = 1'b0;
    value_next = saturate(temp_res);
    unique case (state)
      ST_IDLE: begin
        if (in_beat) begin
          state_next = (op == OP_TEMP) ? ST_MUL_T : ST_MUL_OFF;
        end
      end
      ST_MUL_T: begin
        mul_en     = 1'b1;
        state_next = ST_FIN_T;
      end
      ST_FIN_T: begin
        if (!out_valid || !out_stall) begin
          out_write  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_MUL_OFF: begin
        mul_en     = 1'b1;
        mul_b      = $signed({2'b00, coef.offset_temp_coef});
        state_next = ST_MUL_SENS;
      end
      ST_MUL_SENS: begin
        mul_en     = 1'b1;
        mul_b      = $signed({2'b00, coef.sens_temp_coef});
        state_next = ST_SENS;
      end
      ST_SENS: begin
        state_next = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        mul_en     = 1'b1;
        mul_a      = $signed({1'b0, raw_q});
        mul_b      = $signed({1'b0, sens[SENS_LO_W-1:0]});
        state_next = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        mul_en     = 1'b1;
        mul_a      = $signed({1'b0, raw_q});
        mul_b      = $signed({sens[SENS_W-1], sens[SENS_W-1:SENS_LO_W]});
        state_next = ST_ACC_HI;
      end
      ST_ACC_HI: begin
        state_next = ST_SUB;
      end
      ST_SUB: begin
        state_next = ST_FIN_P;
      end
      ST_FIN_P: begin
        value_next = saturate(diff >>> OUT_SHIFT);
        if (!out_valid || !out_stall) begin
          out_write  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      temp_diff <= '0;
    end else begin
      state     <= state_next;
      out_valid <= (out_valid && out_stall) || out_write;
      if (in_beat && (op == OP_TEMP)) begin
        temp_diff <= $signed(dt_new);
      end
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (in_beat) begin
      raw_q <= raw_value;
      op_q  <= op;
    end
  end

  // accumulators stepped by the sequencer
  always_ff @(posedge clk) begin
    if (state == ST_MUL_SENS) begin
      off <= (OFF_W'($signed({1'b0, coef.offset_at_ref})) <<< OFF_REF_SHIFT)
           + OFF_W'(mul_p >>> OFF_SHIFT);
    end
    if (state == ST_SENS) begin
      sens <= (SENS_W'($signed({1'b0, coef.sens_at_ref})) <<< SENS_REF_SHIFT)
            + SENS_W'(mul_p >>> SENS_SHIFT);
    end
    if (state == ST_MUL_HI) begin
      acc <= ACC_W'(mul_p);
    end
    if (state == ST_ACC_HI) begin
      acc <= acc + (ACC_W'(mul_p) <<< SENS_LO_W);
    end
    if (state == ST_SUB) begin
      diff <= DIFF_W'(acc >>> PROD_SHIFT) - DIFF_W'(off);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_write) begin
      kind  <= op_q;
      value <= value_next;
    end
  end

endmodule

@@ src/baro_sensor_compensation.sv @@
`timescale 1ns / 1ps
// top level of the barometric sensor compensation block
// depends on bsc_pkg, bsc_regs, bsc_mul and bsc_core

// Takes one raw 24-bit conversion per beat, tagged temperature or pressure, and
// returns one result per beat: temperature in centidegrees, or compensated
// pressure, both clamped to a signed 22-bit range. A temperature beat also
// stores the temperature difference used by later pressure beats (zero after
// reset). All math runs on one shared 25x18 signed multiplier under a small
// sequencer, so the block takes one item at a time: a temperature item needs one
// multiply and a write step, a pressure item four multiplies plus accumulate,
// subtract and shift steps and a write step. The result sits
// in an output register, so the next item is taken while it waits to be
// collected. Coefficients are written through the configuration channel, which
// is always ready; indexes six and seven are ignored.

module baro_sensor_compensation (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [bsc_pkg::COEF_W-1:0]            cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  op,
  input  logic [bsc_pkg::RAW_W-1:0]             raw_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  kind,
  output logic signed [bsc_pkg::VALUE_W-1:0]    value
);
  import bsc_pkg::*;

  coef_t                      coef;
  logic                       mul_en;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [MUL_P_W-1:0]  mul_p;

  assign cfg_ready = 1'b1;

  // coefficient registers
  bsc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  // shared multiplier
  bsc_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // sequencer and datapath
  bsc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .coef      (coef),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .raw_value (raw_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .value     (value),
    .mul_en    (mul_en),
    .mul_a     (mul_a),
    .mul_b     (mul_b),
    .mul_p     (mul_p)
  );

endmodule

@@ src/bsc_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for the barometric sensor compensation block
// depends on bsc_pkg; bound to baro_sensor_compensation at the end of this file

module bsc_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic                                  op,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic                                  kind,
  input  logic signed [bsc_pkg::VALUE_W-1:0]    value
);
  import bsc_pkg::*;

  logic last_op;

  // tag of the last accepted beat
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      last_op <= op;
    end
  end

  // reset leaves the block empty and ready
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

  // an accepted beat keeps the input side busy for its computation
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled while an item is in work");

  // a result that raises out_valid carries the tag of the beat that caused it
  a_kind_matches: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> kind == last_op)
    else $error("result kind differs from accepted op");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(value))
    else $error("stalled result changed");

endmodule

bind baro_sensor_compensation bsc_checker u_chk (.*);
